>>> rtl/rxnfa_pkg.sv
// ----------------------------------------------------------------------------
// rxnfa_pkg
// Shared types and constants of the streaming regex NFA matcher.
// ----------------------------------------------------------------------------
package rxnfa_pkg;

    localparam int MAX_ATOMS  = 64;
    localparam int MASK_W     = 64;
    localparam int CNT_W      = 7;
    localparam int PFX_LEVELS = $clog2(MAX_ATOMS);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_MASK   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OPTIONAL_MASK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MASK   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALT_START     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ATOM_COUNT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_ALT     = 3'd5;

    // command codes
    localparam logic CMD_RESTART = 1'b0;
    localparam logic CMD_SYMBOL  = 1'b1;

    // symbol codes
    localparam logic SYM_A = 1'b0;
    localparam logic SYM_B = 1'b1;

    typedef struct packed {
        logic cmd;
        logic symbol;
    } t_in_item;

    typedef struct packed {
        logic accepted;
        logic dead;
    } t_out_item;

    typedef struct packed {
        logic [MASK_W-1:0] symbol_mask;
        logic [MASK_W-1:0] optional_mask;
        logic [MASK_W-1:0] repeat_mask;
        logic [MASK_W-1:0] alt_start_mask;
        logic [CNT_W-1:0]  atom_count;
        logic              empty_alternative;
    } t_cfg;

    // closure results: positions reachable before each atom, atoms in use,
    // and whether some alternative has run to its end
    typedef struct packed {
        logic [MAX_ATOMS-1:0] reach;
        logic [MAX_ATOMS-1:0] used;
        logic [CNT_W-1:0]     n_used;
        logic                 hit;
    } t_clos;

endpackage

>>> rtl/rxnfa_closure.sv
// ----------------------------------------------------------------------------
// rxnfa_closure
// Epsilon closure over the atom chain as a parallel prefix network.
// ----------------------------------------------------------------------------
module rxnfa_closure
    import rxnfa_pkg::*;
(
    input  logic [MAX_ATOMS-1:0] i_act,
    input  logic                 i_start,
    input  t_cfg                 i_cfg,
    output t_clos                o_clos
);

    logic [CNT_W-1:0]     n_used;
    logic [MAX_ATOMS-1:0] alt_first;
    logic [MAX_ATOMS-1:0] used;
    logic [MAX_ATOMS-1:0] last;
    logic [MAX_ATOMS-1:0] cin;
    logic [MAX_ATOMS-1:0] cout;
    logic [MAX_ATOMS-1:0] g [PFX_LEVELS+1];
    logic [MAX_ATOMS-1:0] p [PFX_LEVELS+1];

    assign n_used = (i_cfg.atom_count > CNT_W'(MAX_ATOMS)) ? CNT_W'(MAX_ATOMS)
                                                           : i_cfg.atom_count;

    genvar i, l;
    generate
        for (i = 0; i < MAX_ATOMS; i++) begin : g_pos
            if (i == 0) begin : g_first
                assign alt_first[i] = 1'b1;
                assign cin[i]       = i_start;
            end else begin : g_rest
                assign alt_first[i] = i_cfg.alt_start_mask[i];
                assign cin[i]       = alt_first[i] ? i_start : cout[i-1];
            end
            if (i + 1 < MAX_ATOMS) begin : g_lnext
                assign last[i] = (CNT_W'(i + 1) >= n_used) || i_cfg.alt_start_mask[i+1];
            end else begin : g_lend
                assign last[i] = 1'b1;
            end
            assign used[i] = CNT_W'(i) < n_used;
            // an alternative's first atom sees the start flag, not its left neighbor
            assign g[0][i] = i_act[i] | (alt_first[i] & i_start & i_cfg.optional_mask[i]);
            assign p[0][i] = ~alt_first[i] & i_cfg.optional_mask[i];
        end

        for (l = 0; l < PFX_LEVELS; l++) begin : g_lvl
            localparam int D = 1 << l;
            for (i = 0; i < MAX_ATOMS; i++) begin : g_node
                if (i >= D) begin : g_comb
                    assign g[l+1][i] = g[l][i] | (p[l][i] & g[l][i-D]);
                    assign p[l+1][i] = p[l][i] & p[l][i-D];
                end else begin : g_pass
                    assign g[l+1][i] = g[l][i];
                    assign p[l+1][i] = p[l][i];
                end
            end
        end
    endgenerate

    assign cout = g[PFX_LEVELS];

    assign o_clos.reach  = cin & used;
    assign o_clos.used   = used;
    assign o_clos.n_used = n_used;
    assign o_clos.hit    = (i_start & i_cfg.empty_alternative) | (|(last & cout & used));

endmodule

>>> rtl/regex_nfa_stream_matcher_core.sv
// ----------------------------------------------------------------------------
// regex_nfa_stream_matcher_core
// Streaming matcher of a symbol stream over {a,b} against an alternation of
// atom sequences held as bit masks; one active bit per atom.
//
//  channel | valid       | ready        | payload
//  --------+-------------+--------------+------------------------------
//  input   | i_in_valid  | o_in_ready   | i_in_item  (cmd, symbol)
//  result  | o_out_valid | i_out_ready  | o_out_item (accepted, dead)
//  config  | i_cfg_valid | o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One item per cycle while the output is not stalled. An item updates the atom
// state at its transfer edge; its result is then read off the closure of that
// state and lands in the output register once the output is free. The closure
// is a six-level prefix network over the atoms. Synchronous active-low reset
// initialises state and configuration. A stalled output holds one pending item
// and then drops o_in_ready.
// ----------------------------------------------------------------------------
module regex_nfa_stream_matcher_core
    import rxnfa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg                 r_cfg;
    logic [MAX_ATOMS-1:0] r_active, n_active;
    logic                 r_start, n_start;
    logic                 r_pend;
    logic                 r_out_valid;
    t_out_item            r_out_item, n_out_item;

    t_clos                clos;
    logic [MAX_ATOMS-1:0] match;
    logic                 out_free;
    logic                 in_xfer;
    logic                 pend_move;

    rxnfa_closure u_closure (
        .i_act   (r_active),
        .i_start (r_start),
        .i_cfg   (r_cfg),
        .o_clos  (clos)
    );

    assign out_free   = ~r_out_valid | i_out_ready;
    assign pend_move  = r_pend & out_free;
    assign o_in_ready = ~r_pend | out_free;
    assign in_xfer    = i_in_valid & o_in_ready;
    assign o_cfg_ready = 1'b1;

    assign match = (i_in_item.symbol == SYM_B) ? r_cfg.symbol_mask[MAX_ATOMS-1:0]
                                               : ~r_cfg.symbol_mask[MAX_ATOMS-1:0];

    always_comb begin
        n_active = r_active;
        n_start  = r_start;
        if (in_xfer) begin
            if (i_in_item.cmd == CMD_RESTART) begin
                n_active = '0;
                n_start  = 1'b1;
            end else begin
                n_active = (clos.reach | (r_active & r_cfg.repeat_mask[MAX_ATOMS-1:0]))
                           & match & clos.used;
                n_start  = 1'b0;
            end
        end
    end

    // the result of the pending item is the closure of the current state
    always_comb begin
        n_out_item.accepted = clos.hit;
        n_out_item.dead     = r_start ? (clos.n_used == '0) : (r_active == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= '0;
            r_start     <= 1'b1;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_active <= n_active;
            r_start  <= n_start;
            if (in_xfer) begin
                r_pend <= 1'b1;
            end else if (pend_move) begin
                r_pend <= 1'b0;
            end
            if (pend_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pend_move) begin
            r_out_item <= n_out_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.symbol_mask       <= '0;
            r_cfg.optional_mask     <= '0;
            r_cfg.repeat_mask       <= '0;
            r_cfg.alt_start_mask    <= MASK_W'(1);
            r_cfg.atom_count        <= '0;
            r_cfg.empty_alternative <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SYMBOL_MASK:   r_cfg.symbol_mask       <= i_cfg_data[MASK_W-1:0];
                REG_OPTIONAL_MASK: r_cfg.optional_mask     <= i_cfg_data[MASK_W-1:0];
                REG_REPEAT_MASK:   r_cfg.repeat_mask       <= i_cfg_data[MASK_W-1:0];
                REG_ALT_START:     r_cfg.alt_start_mask    <= i_cfg_data[MASK_W-1:0];
                REG_ATOM_COUNT:    r_cfg.atom_count        <= i_cfg_data[CNT_W-1:0];
                REG_EMPTY_ALT:     r_cfg.empty_alternative <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> rtl/rxnfa_checker.sv
// ----------------------------------------------------------------------------
// rxnfa_checker
// Port-level checks of the matcher: flow control and item bookkeeping.
// ----------------------------------------------------------------------------
module rxnfa_checker
    import rxnfa_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input t_out_item             o_out_item,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready
);

    // items taken in but whose result has not been transferred out yet
    logic [1:0] r_cnt;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = i_in_valid & o_in_ready;
    assign out_xfer = o_out_valid & i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (in_xfer && !out_xfer) begin
            r_cnt <= r_cnt + 2'd1;
        end else if (!in_xfer && out_xfer) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result dropped or changed while stalled");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_cnt != 2'd0)
        else $error("result shown with no item outstanding");

    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("more items held than the pipeline can carry");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without an output stall");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("config transfer refused");

endmodule

bind regex_nfa_stream_matcher_core rxnfa_checker u_rxnfa_checker (.*);
